[hw/rtl/assert_macros.svh]
// assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[hw/rtl/hbwe_pkg.sv]
// package: types and constants for the hermite basis weight evaluator
`timescale 1ns / 1ps
`default_nettype none
package hbwe_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IDX_W = 6;
    localparam int COORD_W = 17;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] coordinate;
    } hbwe_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   first_index;
        logic [COORD_W-1:0] first_weight;
        logic [IDX_W-1:0]   second_index;
        logic [COORD_W-1:0] second_weight;
        logic [1:0]         weight_count;
    } hbwe_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/hermite_basis_weight_evaluator.sv]
// hermite basis weight evaluator: grid table, scan, serial divide, cubic hat
// usage:
//   req channel (req_valid/req_ready) carries one request: mode 0 loads
//   coordinate into grid slot point_index and sets the point count to index
//   plus one; mode 1 evaluates the hat basis at coordinate.
//   rsp channel (rsp_valid/rsp_ready) returns one result per evaluate request,
//   none per load; pairs that carry no weight read as zero.
// sequence:
//   load: written when the request is taken. evaluate: read the first point,
//   then scan further points (one ram read each), fetch the left neighbor,
//   run the restoring divider, compute the hat on the shared multiplier
//   per weight (two weights between points), then load the result register.
//   one request at a time.
// reset:
//   the point count clears; grid entries are undefined until loaded.
// stall:
//   a held result waits in the output register; the next request is taken
//   only after the result is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hermite_basis_weight_evaluator #(
    parameter int MAX_POINTS = hbwe_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = hbwe_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire hbwe_pkg::hbwe_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output hbwe_pkg::hbwe_rsp_t    rsp
);
    import hbwe_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VW = FRAC_BITS + 1;
    localparam int DW = 2 * FRAC_BITS + 2;
    localparam int PW = 2 * VW + 2;
    localparam int DIV_N = FRAC_BITS + VW;
    localparam int DCW = $clog2(DIV_N + 1);
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_WT0, S_CHK0, S_RD, S_WT, S_CHK, S_RDP, S_WTP, S_GOTP,
        S_DIV, S_H0, S_H1, S_H2, S_H3, S_H4, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] i_reg;
    logic [VW-1:0] e_reg, xi_reg, u_reg, u2_reg;
    logic [VW:0]   w_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] num_reg;
    logic [VW-1:0] den_reg;
    logic [VW:0]   q_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [PW-1:0] prod_reg;
    logic          pass_reg;
    logic [1:0]    kind_reg;
    logic [AW-1:0] ia_reg, ib_reg;
    hbwe_rsp_t     rsp_reg;
    logic          rsp_valid_reg;

    logic          we;
    logic [AW-1:0] addr;
    logic [VW-1:0] rdata;
    logic [VW-1:0] e_in;
    logic [VW-1:0] mul_a;
    logic [VW:0]   mul_b;
    logic [PW-1:0] mul_p;
    logic [DW-1:0] rem_sh;
    logic [VW:0]   qsat;
    logic [VW-1:0] hval;

    assign e_in = (req.coordinate > COORD_W'(ONE)) ? ONE : VW'(req.coordinate);
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign we = req_valid && req_ready && (req.mode == MODE_LOAD)
        && ({26'd0, req.point_index} < 32'(MAX_POINTS));
    assign addr = (state_reg == S_IDLE) ? AW'(req.point_index) : AW'(i_reg);

    hbwe_ram #(.WIDTH(VW), .DEPTH(1 << AW)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(e_in),
        .rdata(rdata)
    );

    assign mul_p = PW'(mul_a) * PW'(mul_b);
    always_comb
    begin
        case (state_reg)
            S_H3:
            begin
                mul_a = u2_reg;
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = u_reg;
                mul_b = {1'b0, u_reg};
            end
        endcase
    end
    assign rem_sh = {rem_reg[DW-2:0], num_reg[DW-1]};
    assign qsat = (q_reg > {1'b0, ONE}) ? {1'b0, ONE} : q_reg;
    assign hval = (prod_reg > PW'(ONE)) ? VW'(0) : VW'(ONE - VW'(prod_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        e_reg <= e_in;
                        if (req.mode == MODE_LOAD)
                        begin
                            if (we)
                            begin
                                count_reg <= CW'(req.point_index) + CW'(1);
                            end
                        end
                        else
                        begin
                            rsp_reg <= '0;
                            i_reg <= '0;
                            if (count_reg == '0)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_RD0;
                            end
                        end
                    end
                end
                S_RD0: state_reg <= S_WT0;
                S_WT0: state_reg <= S_CHK0;
                S_CHK0:
                begin
                    if (e_reg == '0 && rdata == '0)
                    begin
                        rsp_reg.first_weight <= COORD_W'(ONE);
                        rsp_reg.weight_count <= 2'd1;
                        state_reg <= S_OUT;
                    end
                    else if (e_reg <= rdata)
                    begin
                        if (rdata == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            kind_reg <= 2'd0;
                            num_reg <= DW'(e_reg) << FRAC_BITS;
                            den_reg <= rdata;
                            rem_reg <= '0;
                            q_reg <= '0;
                            dcnt_reg <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        i_reg <= CW'(1);
                        kind_reg <= 2'd2;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (i_reg >= count_reg)
                    begin
                        i_reg <= count_reg - CW'(1);
                        state_reg <= S_RDP;
                    end
                    else
                    begin
                        state_reg <= S_WT;
                    end
                end
                S_WT: state_reg <= S_CHK;
                S_CHK:
                begin
                    if (e_reg <= rdata)
                    begin
                        xi_reg <= rdata;
                        i_reg <= i_reg - CW'(1);
                        state_reg <= S_RDP;
                        kind_reg <= 2'd1;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_RD;
                        kind_reg <= 2'd2;
                    end
                end
                S_RDP: state_reg <= S_WTP;
                S_WTP: state_reg <= S_GOTP;
                S_GOTP:
                begin
                    rem_reg <= '0;
                    q_reg <= '0;
                    dcnt_reg <= '0;
                    ia_reg <= AW'(i_reg);
                    ib_reg <= AW'(i_reg + CW'(1));
                    num_reg <= DW'(e_reg - rdata) << FRAC_BITS;
                    if (kind_reg == 2'd1)
                    begin
                        den_reg <= xi_reg - rdata;
                        state_reg <= S_DIV;
                    end
                    else if (rdata < ONE && e_reg > rdata)
                    begin
                        den_reg <= ONE - rdata;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[DW-2:0], 1'b0};
                    if (rem_sh >= DW'(den_reg))
                    begin
                        rem_reg <= rem_sh - DW'(den_reg);
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                    end
                    if (q_reg[VW])
                    begin
                        q_reg <= {1'b1, {VW{1'b0}}};
                    end
                    else
                    begin
                        q_reg <= {q_reg[VW-1:0], rem_sh >= DW'(den_reg)};
                    end
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(DW - 1))
                    begin
                        state_reg <= S_H0;
                        pass_reg <= 1'b0;
                    end
                end
                S_H0:
                begin
                    if (kind_reg == 2'd0 || (kind_reg == 2'd1 && pass_reg))
                    begin
                        u_reg <= ONE - VW'(qsat);
                    end
                    else
                    begin
                        u_reg <= VW'(qsat);
                    end
                    state_reg <= S_H1;
                end
                S_H1: state_reg <= S_H2;
                S_H2:
                begin
                    state_reg <= S_H3;
                end
                S_H3: state_reg <= S_H4;
                S_H4:
                begin
                    if (hval != '0)
                    begin
                        if (rsp_reg.weight_count == 2'd0)
                        begin
                            rsp_reg.first_index <= IDX_W'(pass_reg ? ib_reg :
                                (kind_reg == 2'd0 ? AW'(0) : ia_reg));
                            rsp_reg.first_weight <= COORD_W'(hval);
                        end
                        else
                        begin
                            rsp_reg.second_index <= IDX_W'(ib_reg);
                            rsp_reg.second_weight <= COORD_W'(hval);
                        end
                        rsp_reg.weight_count <= rsp_reg.weight_count + 2'd1;
                    end
                    if (kind_reg == 2'd1 && !pass_reg)
                    begin
                        pass_reg <= 1'b1;
                        state_reg <= S_H0;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hat pipeline on the shared multiplier: u*u, then u2*(3-2u)
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_H1: u2_reg <= VW'(mul_p >> FRAC_BITS);
            S_H2: w_reg <= {ONE, 1'b0} + {1'b0, ONE} - {u_reg, 1'b0};
            S_H3: prod_reg <= mul_p >> FRAC_BITS;
            default: ;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, req_ready, state_reg == S_IDLE)
    `ASSERT_IMPLIES(a_cnt_le2, clk, rst_n, rsp_valid, rsp.weight_count != 2'd3)
    `ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
endmodule
`default_nettype wire

[hw/rtl/hbwe_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hbwe_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
